FILE: rtl/cdpf_pkg.sv
package cdpf_pkg;

	// Default sizes of the history ring
	localparam int HISTORY_FRAMES_DEF = 5;
	localparam int MAX_CIRCLES_DEF    = 8;

	// Register widths
	localparam int DIM_W   = 16;
	localparam int LIMIT_W = 12;
	localparam int MLIM_W  = 3;
	localparam int MATCH_W = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 16'd10240;
	localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 16'd7680;
	localparam logic [LIMIT_W-1:0] X_LIMIT_RST      = 12'd240;
	localparam logic [LIMIT_W-1:0] Y_LIMIT_RST      = 12'd240;
	localparam logic [LIMIT_W-1:0] RADIUS_LIMIT_RST = 12'd320;
	localparam logic [MLIM_W-1:0]  MATCH_LIMIT_RST  = 3'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_LIMIT  = 3'd5;

	// Item opcodes
	localparam logic OP_CIRCLE = 1'b0;
	localparam logic OP_EOF    = 1'b1;

	localparam logic [MATCH_W-1:0] MATCH_SAT = 3'd7;

	typedef struct packed {
		logic             op;
		logic [DIM_W-1:0] center_x;
		logic [DIM_W-1:0] center_y;
		logic [DIM_W-1:0] radius;
	} item_t;

	typedef struct packed {
		logic               frame_closed;
		logic               inside_frame;
		logic [MATCH_W-1:0] matching_frames;
		logic               stable;
		logic               dropped;
	} result_t;

	typedef struct packed {
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
		logic [DIM_W-1:0] r;
	} circle_t;

	localparam int CIRCLE_W = $bits(circle_t);

	typedef struct packed {
		logic [LIMIT_W-1:0] x_limit;
		logic [LIMIT_W-1:0] y_limit;
		logic [LIMIT_W-1:0] radius_limit;
	} limits_t;

	// Broadcast command from the sequencer to every cell
	typedef struct packed {
		logic    store;       // circle transfer: current cell appends wr_circle unless full
		logic    clear;       // end of frame: next cell empties itself
		logic    clear_hits;  // start of a new search
		logic    compare;     // read data valid, compare against query
		logic    shift;       // hit flags move one cell toward cell 0
		circle_t wr_circle;
		circle_t query;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH,
		ST_SUM,
		ST_DONE
	} state_t;

	function automatic logic [DIM_W-1:0] abs_diff(input logic [DIM_W-1:0] a,
		input logic [DIM_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

FILE: rtl/cdpf_ram.sv
module cdpf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/cdpf_cell.sv
module cdpf_cell import cdpf_pkg::*; #(
	parameter int MAX_CIRCLES = MAX_CIRCLES_DEF,
	localparam int IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1,
	localparam int CNT_W = $clog2(MAX_CIRCLES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic             is_cur,
	input  logic             is_next,
	input  logic [IDX_W-1:0] rd_idx,
	input  logic [IDX_W-1:0] cmp_idx,
	input  limits_t          limits,
	input  logic             hit_in,
	output logic             hit_out,
	output logic             full
);

	logic [CNT_W-1:0] count_q;
	logic             hit_q;
	logic             wr_en;
	circle_t          entry;
	logic             entry_valid;
	logic             similar;

	assign full  = (count_q == CNT_W'(MAX_CIRCLES));
	assign wr_en = cmd.store && is_cur && !full;

	cdpf_ram #(
		.WIDTH(CIRCLE_W),
		.DEPTH(MAX_CIRCLES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(cmd.wr_circle),
		.raddr(rd_idx),
		.rdata(entry)
	);

	// Fill count of this frame slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear && is_next) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Compare the entry read last cycle with the query
	always_comb begin
		entry_valid = (CNT_W'(cmp_idx) < count_q);
		similar = (abs_diff(entry.x, cmd.query.x) < DIM_W'(limits.x_limit)) &&
			(abs_diff(entry.y, cmd.query.y) < DIM_W'(limits.y_limit)) &&
			(abs_diff(entry.r, cmd.query.r) < DIM_W'(limits.radius_limit));
	end

	// Hit flag: set by the walk, then shifted out through the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.clear_hits) begin
			hit_q <= 1'b0;
		end else if (cmd.shift) begin
			hit_q <= hit_in;
		end else if (cmd.compare && entry_valid && similar && !is_cur) begin
			hit_q <= 1'b1;
		end
	end

	assign hit_out = hit_q;

endmodule

FILE: rtl/circle_detection_persistence_filter.sv
// Persistence filter for circle detections.
// Item channel (item_valid / item_stall / item): one circle detection or an
// end-of-frame marker per transfer. Result channel (result_valid /
// result_stall / result): exactly one result per item, in order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; write only while the block is idle.
// An end-of-frame item or a circle outside the frame goes straight to the
// done state, from which its result is loaded into the output register. A
// circle inside the frame passes the walk, flush and sum states: each frame
// cell walks its circle RAM one entry per cycle through its read port, then
// the hit flags shift out of the cell chain one cell per cycle.
// One item is in work at a time; item_stall is high from the transfer until
// the result is loaded into the output register, so the next item can be
// taken while a result still waits there.
// While result_stall is high a held result stays, and a finished item waits.
// Reset empties every frame slot, selects slot 0 and restores register
// defaults; no clearing pass is needed.
module circle_detection_persistence_filter import cdpf_pkg::*; #(
	parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEF,
	parameter int MAX_CIRCLES    = MAX_CIRCLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SLOTS  = HISTORY_FRAMES + 1;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int IDX_W  = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
	localparam int SUM_W  = $clog2(SLOTS);

	// Configuration registers
	logic [DIM_W-1:0]   frame_width_q;
	logic [DIM_W-1:0]   frame_height_q;
	limits_t            limits_q;
	logic [MLIM_W-1:0]  match_limit_q;

	// Sequencer state
	state_t             state_q, state_d;
	logic [SLOT_W-1:0]  cur_q;
	logic [SLOT_W-1:0]  next_slot;
	logic [IDX_W-1:0]   k_q;
	logic               walk_s1;
	logic [IDX_W-1:0]   k_s1;
	logic [SUM_W-1:0]   sum_cnt_q;
	logic [MATCH_W-1:0] match_q;
	logic               inside_q;
	logic               eof_q;
	logic               dropped_q;
	circle_t            query_q;
	result_t            result_q;
	logic               result_valid_q;

	logic               accept;
	logic               in_frame;
	logic               dropped;
	logic               walk_last;
	logic               sum_last;
	logic               res_free;
	logic               load_res;
	logic               walk_en;
	logic               shift_en;
	logic [DIM_W:0]     sum_x;
	logic [DIM_W:0]     sum_y;
	circle_t            item_circle;
	cell_cmd_t          cmd;

	logic [SLOTS-1:0]   full;
	logic [SLOTS-1:0]   hit;
	logic [SLOTS-1:0]   is_cur;
	logic [SLOTS-1:0]   is_next;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q         <= FRAME_WIDTH_RST;
			frame_height_q        <= FRAME_HEIGHT_RST;
			limits_q.x_limit      <= X_LIMIT_RST;
			limits_q.y_limit      <= Y_LIMIT_RST;
			limits_q.radius_limit <= RADIUS_LIMIT_RST;
			match_limit_q         <= MATCH_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_X_LIMIT:      limits_q.x_limit <= cfg_data[LIMIT_W-1:0];
				REG_Y_LIMIT:      limits_q.y_limit <= cfg_data[LIMIT_W-1:0];
				REG_RADIUS_LIMIT: limits_q.radius_limit <= cfg_data[LIMIT_W-1:0];
				REG_MATCH_LIMIT:  match_limit_q <= cfg_data[MLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Bounds check and slot-full lookup for the item at the input
	always_comb begin
		item_circle.x = item.center_x;
		item_circle.y = item.center_y;
		item_circle.r = item.radius;
		sum_x = {1'b0, item.center_x} + {1'b0, item.radius};
		sum_y = {1'b0, item.center_y} + {1'b0, item.radius};
		in_frame = !((item.center_x < item.radius) || (item.center_y < item.radius) ||
			(sum_x >= {1'b0, frame_width_q}) || (sum_y >= {1'b0, frame_height_q}));
		dropped = |(full & is_cur);
		next_slot = (cur_q == SLOT_W'(SLOTS - 1)) ? '0 : cur_q + SLOT_W'(1);
	end

	assign accept    = item_valid && !item_stall;
	assign walk_last = (k_q == IDX_W'(MAX_CIRCLES - 1));
	assign sum_last  = (sum_cnt_q == SUM_W'(SLOTS - 1));
	assign res_free  = !result_valid_q || !result_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.op == OP_EOF || !in_frame) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (walk_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_SUM;
			ST_SUM: begin
				if (sum_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		item_stall = 1'b1;
		walk_en    = 1'b0;
		shift_en   = 1'b0;
		load_res   = 1'b0;
		case (state_q)
			ST_IDLE:  item_stall = 1'b0;
			ST_WALK:  walk_en = 1'b1;
			ST_FLUSH: ;
			ST_SUM:   shift_en = 1'b1;
			ST_DONE:  load_res = res_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Slot ring, walk index and hit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			k_q       <= '0;
			walk_s1   <= 1'b0;
			sum_cnt_q <= '0;
			match_q   <= '0;
		end else begin
			walk_s1 <= walk_en;
			if (accept && item.op == OP_EOF) begin
				cur_q <= next_slot;
			end
			if (accept) begin
				k_q       <= '0;
				sum_cnt_q <= '0;
				match_q   <= '0;
			end else begin
				if (walk_en) begin
					k_q <= k_q + IDX_W'(1);
				end
				if (shift_en) begin
					sum_cnt_q <= sum_cnt_q + SUM_W'(1);
					if (hit[0] && match_q != MATCH_SAT) begin
						match_q <= match_q + MATCH_W'(1);
					end
				end
			end
		end
	end

	// Read index delayed to line up with the registered RAM data
	always_ff @(posedge clk) begin
		k_s1 <= k_q;
	end

	// Item details kept for the result
	always_ff @(posedge clk) begin
		if (accept) begin
			query_q   <= item_circle;
			eof_q     <= (item.op == OP_EOF);
			inside_q  <= (item.op == OP_CIRCLE) && in_frame;
			dropped_q <= (item.op == OP_CIRCLE) && dropped;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_res) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			result_q.frame_closed    <= eof_q;
			result_q.inside_frame    <= inside_q;
			result_q.matching_frames <= inside_q ? match_q : '0;
			result_q.stable          <= inside_q && (match_q > match_limit_q);
			result_q.dropped         <= dropped_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Command broadcast to the cells
	always_comb begin
		cmd.store      = accept && (item.op == OP_CIRCLE);
		cmd.clear      = accept && (item.op == OP_EOF);
		cmd.clear_hits = accept;
		cmd.compare    = walk_s1;
		cmd.shift      = shift_en;
		cmd.wr_circle  = item_circle;
		cmd.query      = query_q;
	end

	// Row of frame cells; hit flags travel toward cell 0
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic hit_in;

		assign is_cur[i]  = (cur_q == SLOT_W'(i));
		assign is_next[i] = (next_slot == SLOT_W'(i));

		if (i == SLOTS - 1) begin : g_tail
			assign hit_in = 1'b0;
		end else begin : g_link
			assign hit_in = hit[i+1];
		end

		cdpf_cell #(
			.MAX_CIRCLES(MAX_CIRCLES)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.is_cur (is_cur[i]),
			.is_next(is_next[i]),
			.rd_idx (k_q),
			.cmp_idx(k_s1),
			.limits (limits_q),
			.hit_in (hit_in),
			.hit_out(hit[i]),
			.full   (full[i])
		);
	end

endmodule
